// ===== rtl/pidd_pkg.sv =====
// pidd_pkg: widths, event and register codes, reset values and the
// controller/datapath command and status structs of the duty decoder
// no dependencies
package pidd_pkg;

   localparam int CMD_W      = 2;
   localparam int CAP_W      = 16;
   localparam int CNT_W      = 16;
   localparam int TICK_W     = 32;
   localparam int SCALE_W    = 12;
   localparam int PROD_W     = TICK_W + SCALE_W;
   localparam int STEP_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CMD_W-1:0] CMD_OVERFLOW = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PERIOD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DUTY     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RELOAD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE   = 2'd2;

   localparam logic [CNT_W-1:0]   RELOAD_RST  = 16'd65535;
   localparam logic [CNT_W-1:0]   TIMEOUT_RST = 16'd20;
   localparam logic [SCALE_W-1:0] SCALE_RST   = 12'd2000;

   localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(SCALE_W - 1);

   typedef struct packed {
      logic load_in;
      logic calc_ticks;
      logic apply;
      logic calc_prod;
      logic div_step;
      logic div_write;
      logic load_out;
   } pidd_cmd_type;

   typedef struct packed {
      logic div_needed;
      logic div_last;
   } pidd_status_type;

endpackage

// ===== rtl/pidd_if.sv =====
// pidd_if: request, response and csr write channels of the duty decoder
// depends on pidd_pkg
interface pidd_req_if import pidd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [CAP_W-1:0] capture_value;
   logic             pin_level;

   modport source (output valid, cmd, capture_value, pin_level, input ready);
   modport sink   (input valid, cmd, capture_value, pin_level, output ready);
endinterface

interface pidd_rsp_if import pidd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SCALE_W-1:0] request;
   logic [TICK_W-1:0]  period_ticks;
   logic [TICK_W-1:0]  high_ticks;
   logic               timed_out;

   modport source (output valid, request, period_ticks, high_ticks, timed_out,
                   input ready);
   modport sink   (input valid, request, period_ticks, high_ticks, timed_out,
                   output ready);
endinterface

interface pidd_csr_if import pidd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/pidd_datapath.sv =====
// pidd_datapath: config and measurement registers, tick multiplier,
// duty product and 12-step restoring divider, response payload register
// depends on pidd_pkg
module pidd_datapath import pidd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  pidd_cmd_type          ctl,
   output pidd_status_type       status,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [CAP_W-1:0]      req_capture_value,
   input  logic                  req_pin_level,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic [SCALE_W-1:0]    rsp_request,
   output logic [TICK_W-1:0]     rsp_period_ticks,
   output logic [TICK_W-1:0]     rsp_high_ticks,
   output logic                  rsp_timed_out
);

   logic [CMD_W-1:0]   cmd_ff;
   logic [CAP_W-1:0]   cap_ff;
   logic               pin_ff;
   logic [CNT_W-1:0]   reload_ff;
   logic [CNT_W-1:0]   timeout_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [CNT_W-1:0]   ovf_ff, ovf_in;
   logic [TICK_W-1:0]  period_ff, period_in;
   logic [TICK_W-1:0]  high_ff, high_in;
   logic [SCALE_W-1:0] level_ff, level_in;
   logic [TICK_W-1:0]  ticks_ff;
   logic [PROD_W-1:0]  rem_ff;
   logic [PROD_W-1:0]  dvs_ff;
   logic [SCALE_W-1:0] quo_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [SCALE_W-1:0] out_request_ff;
   logic [TICK_W-1:0]  out_period_ff;
   logic [TICK_W-1:0]  out_high_ff;
   logic               out_timed_ff;

   logic [TICK_W-1:0]  mult;
   logic [TICK_W-1:0]  ticks;
   logic [CNT_W-1:0]   ovf_inc;
   logic [PROD_W-1:0]  prod;
   logic               rem_ge;

   assign mult    = TICK_W'(ovf_ff) * TICK_W'(reload_ff);
   assign ticks   = mult + TICK_W'(cap_ff);
   assign ovf_inc = (ovf_ff != '1) ? ovf_ff + 1'b1 : ovf_ff;
   assign prod    = PROD_W'(period_ff - high_ff) * PROD_W'(scale_ff);
   assign rem_ge  = rem_ff >= dvs_ff;

   assign status.div_needed = (cmd_ff == CMD_PERIOD) && (ticks_ff != '0)
                              && (high_ff < ticks_ff);
   assign status.div_last   = step_ff == DIV_LAST_STEP;

   always_comb begin
      ovf_in    = ovf_ff;
      period_in = period_ff;
      high_in   = high_ff;
      level_in  = level_ff;
      if (ctl.apply) begin
         unique case (cmd_ff)
            CMD_OVERFLOW: begin
               ovf_in = ovf_inc;
               if (ovf_inc > timeout_ff) begin
                  level_in = pin_ff ? '0 : scale_ff;
               end
            end
            CMD_PERIOD: begin
               period_in = ticks_ff;
               ovf_in    = '0;
               if ((ticks_ff != '0) && (high_ff >= ticks_ff)) begin
                  level_in = '0;
               end
            end
            CMD_DUTY: begin
               high_in = ticks_ff;
            end
            default: begin
            end
         endcase
      end else if (ctl.div_write) begin
         level_in = quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff  <= RELOAD_RST;
         timeout_ff <= TIMEOUT_RST;
         scale_ff   <= SCALE_RST;
         ovf_ff     <= '0;
         period_ff  <= '0;
         high_ff    <= '0;
         level_ff   <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_RELOAD:  reload_ff  <= csr_data;
               CSR_TIMEOUT: timeout_ff <= csr_data;
               CSR_SCALE:   scale_ff   <= csr_data[SCALE_W-1:0];
               default: begin
               end
            endcase
         end
         ovf_ff    <= ovf_in;
         period_ff <= period_in;
         high_ff   <= high_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_in) begin
         cmd_ff <= req_cmd;
         cap_ff <= req_capture_value;
         pin_ff <= req_pin_level;
      end
      if (ctl.calc_ticks) begin
         ticks_ff <= ticks;
      end
      if (ctl.calc_prod) begin
         rem_ff  <= prod;
         dvs_ff  <= PROD_W'({period_ff, {(SCALE_W-1){1'b0}}});
         quo_ff  <= '0;
         step_ff <= '0;
      end else if (ctl.div_step) begin
         if (rem_ge) begin
            rem_ff <= rem_ff - dvs_ff;
         end
         quo_ff  <= {quo_ff[SCALE_W-2:0], rem_ge};
         dvs_ff  <= dvs_ff >> 1;
         step_ff <= step_ff + 1'b1;
      end
      if (ctl.load_out) begin
         out_request_ff <= level_ff;
         out_period_ff  <= period_ff;
         out_high_ff    <= high_ff;
         out_timed_ff   <= ovf_ff > timeout_ff;
      end
   end

   assign rsp_request      = out_request_ff;
   assign rsp_period_ticks = out_period_ff;
   assign rsp_high_ticks   = out_high_ff;
   assign rsp_timed_out    = out_timed_ff;

endmodule

// ===== rtl/pidd_controller.sv =====
// pidd_controller: sequencer that steps one request through the datapath
// and owns the request ready and response valid handshake
// depends on pidd_pkg
module pidd_controller import pidd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  pidd_status_type status,
   output pidd_cmd_type    ctl
);

   typedef enum logic [2:0] {
      S_IDLE, S_TICKS, S_APPLY, S_PROD, S_DIV, S_WRITE, S_OUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctl = '0;
      unique case (state_ff)
         S_IDLE:  ctl.load_in    = req_valid;
         S_TICKS: ctl.calc_ticks = 1'b1;
         S_APPLY: ctl.apply      = 1'b1;
         S_PROD:  ctl.calc_prod  = 1'b1;
         S_DIV:   ctl.div_step   = 1'b1;
         S_WRITE: ctl.div_write  = 1'b1;
         S_OUT:   ctl.load_out   = !rsp_valid_ff || rsp_ready;
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_TICKS;
               end
            end
            S_TICKS: state_ff <= S_APPLY;
            S_APPLY: state_ff <= status.div_needed ? S_PROD : S_OUT;
            S_PROD:  state_ff <= S_DIV;
            S_DIV: begin
               if (status.div_last) begin
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: state_ff <= S_OUT;
            S_OUT: begin
               if (ctl.load_out) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/pwm_input_duty_decoder.sv =====
// PWM input duty decoder. Each request is one timer event (overflow tick,
// period-edge capture or duty-edge capture) and yields exactly one response
// with the updated request level, period, high time and timeout flag. One
// request is in flight at a time: ticks, duty edges and period edges that need
// no division pass from acceptance through the ticks, apply and output steps
// to response valid; period edges that need a new duty value also pass the
// product step, the 12-step restoring divider that forms (period - high) *
// full_scale / period one quotient bit per cycle, and the write step. Ready
// returns in the same cycle that response valid rises. A response waits in an
// output register, so the next request is taken while it is pending; that
// request then holds in its last step until the pending response is taken.
// Csr writes are always ready and must only be issued while idle.
// Depends on pidd_pkg, pidd_if, pidd_datapath and pidd_controller.
module pwm_input_duty_decoder import pidd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   pidd_req_if.sink   req_ch,
   pidd_rsp_if.source rsp_ch,
   pidd_csr_if.sink   csr_ch
);

   pidd_cmd_type    ctl;
   pidd_status_type status;

   assign csr_ch.ready = 1'b1;

   pidd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .ctl       (ctl)
   );

   pidd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .status            (status),
      .req_cmd           (req_ch.cmd),
      .req_capture_value (req_ch.capture_value),
      .req_pin_level     (req_ch.pin_level),
      .csr_write         (csr_ch.valid),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .rsp_request       (rsp_ch.request),
      .rsp_period_ticks  (rsp_ch.period_ticks),
      .rsp_high_ticks    (rsp_ch.high_ticks),
      .rsp_timed_out     (rsp_ch.timed_out)
   );

endmodule

// ===== rtl/pidd_checker.sv =====
// pidd_checker: port-level assertions on the duty decoder handshakes,
// bound to pwm_input_duty_decoder; depends on pidd_pkg
module pidd_checker import pidd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [SCALE_W-1:0] rsp_request,
   input logic [TICK_W-1:0]  rsp_period_ticks,
   input logic [TICK_W-1:0]  rsp_high_ticks,
   input logic               rsp_timed_out
);

   logic req_accept;
   assign req_accept = req_valid && req_ready;

   // pending response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_request)
         && $stable(rsp_period_ticks) && $stable(rsp_high_ticks)
         && $stable(rsp_timed_out))
      else $error("response changed while stalled");

   // one request in flight
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ready)
      else $error("request accepted while busy");

   // no response appears sooner than the minimum latency
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid)
         ##1 !$rose(rsp_valid))
      else $error("response too early");

endmodule

bind pwm_input_duty_decoder pidd_checker u_pidd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_request      (rsp_ch.request),
   .rsp_period_ticks (rsp_ch.period_ticks),
   .rsp_high_ticks   (rsp_ch.high_ticks),
   .rsp_timed_out    (rsp_ch.timed_out)
);
